[hdl/asrs_pkg.sv]
// Shared types, codes and constants for the acked sequence ring store.
`default_nettype none
package asrs_pkg;

  // Default build sizes.
  localparam int SLOTS_MAX_DEF    = 1024;
  localparam int PAYLOAD_BITS_DEF = 32;
  localparam int PEEK_MAX_DEF     = 64;

  // Fixed field widths.
  localparam int SEQ_W  = 32;
  localparam int WORD_W = 32;
  localparam int CFG_W  = 11;
  localparam int ACT_W  = 2;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;
  localparam int PEND_W = 11;

  // Action codes on the input port.
  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  // Classified command passed from the front end to the back end.
  typedef enum logic [1:0] {
    OP_PUSH,
    OP_ACK,
    OP_PEEK,
    OP_BAD_COUNT
  } op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 2'd0,
    ST_ACK_IGNORED = 2'd1,
    ST_NONE_FOUND  = 2'd2,
    ST_BAD_COUNT   = 2'd3
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] payload;
    logic [SEQ_W-1:0]  ack_seq;
    logic [CNT_W-1:0]  count;
  } cmd_t;

  // Back end sequencer states.
  typedef enum logic [3:0] {
    B_IDLE,
    B_RESYNC,
    B_EXEC,
    B_FIRST,
    B_PEND,
    B_REPORT,
    B_DIV,
    B_WALK_RD,
    B_WALK_CK
  } back_state_t;

endpackage
`default_nettype wire

[hdl/asrs_div.sv]
// Iterative remainder unit: one dividend bit per cycle against the slot count.
`default_nettype none
module asrs_div #(
  parameter int CAP_W  = 11,
  parameter int SLOT_W = 10
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [asrs_pkg::SEQ_W-1:0] dividend,
  input  wire logic [CAP_W-1:0]         divisor,
  output logic                          done,
  output logic [SLOT_W-1:0]             remainder
);
  import asrs_pkg::*;

  localparam int STEP_W = $clog2(SEQ_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SEQ_W - 1);

  logic              active;
  logic [STEP_W-1:0] step;
  logic [SEQ_W-1:0]  shift;
  logic [CAP_W-1:0]  rem;
  logic [CAP_W:0]    trial;
  logic [CAP_W:0]    diff;
  logic              fits;

  // Shift in the next dividend bit and subtract when the divisor fits.
  always_comb begin
    trial = {rem, shift[SEQ_W-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  // Control of the iteration.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      step   <= '0;
    end else begin
      done <= active && (step == STEP_LAST);
      if (start) begin
        active <= 1'b1;
        step   <= '0;
      end else if (active) begin
        step <= step + 1'b1;
        if (step == STEP_LAST) begin
          active <= 1'b0;
        end
      end
    end
  end

  // Datapath of the iteration.
  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      rem   <= '0;
    end else if (active) begin
      shift <= shift << 1;
      rem   <= fits ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
    end
  end

  assign remainder = rem[SLOT_W-1:0];

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done |-> (rem < divisor))
    else $error("remainder not below divisor");

endmodule
`default_nettype wire

[hdl/asrs_front.sv]
// Front end: takes items, classifies them and queues the commands.
`default_nettype none
module asrs_front #(
  parameter int PEEK_MAX = asrs_pkg::PEEK_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [asrs_pkg::ACT_W-1:0]  action,
  input  wire logic [asrs_pkg::WORD_W-1:0] record_payload,
  input  wire logic [asrs_pkg::SEQ_W-1:0]  ack_seq,
  input  wire logic [asrs_pkg::CNT_W-1:0]  max_count,
  input  wire logic                        resync,
  output logic                             busy,
  output logic                             cmd_valid,
  output asrs_pkg::cmd_t                   cmd,
  input  wire logic                        cmd_pop
);
  import asrs_pkg::*;

  localparam int QDEPTH = 2;
  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(PEEK_MAX);

  cmd_t       queue_mem [QDEPTH];
  logic [1:0] fill;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       accept;
  logic       keep;
  logic       push_en;
  cmd_t       new_cmd;

  // The queue is full, or the slot pointer is being rebuilt after a capacity change.
  assign busy    = (fill == 2'(QDEPTH)) || resync;
  assign accept  = start && !busy;
  assign push_en = accept && keep;

  // Classify the item; an unused action is dropped here.
  always_comb begin
    new_cmd.payload = record_payload;
    new_cmd.ack_seq = ack_seq;
    new_cmd.count   = (max_count > COUNT_CAP) ? COUNT_CAP : max_count;
    new_cmd.op      = OP_PUSH;
    keep            = 1'b1;
    unique case (action)
      ACT_PUSH: new_cmd.op = OP_PUSH;
      ACT_ACK:  new_cmd.op = OP_ACK;
      ACT_PEEK: new_cmd.op = (max_count == '0) ? OP_BAD_COUNT : OP_PEEK;
      default:  keep = 1'b0;
    endcase
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_en, cmd_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      queue_mem[wr_ptr] <= new_cmd;
    end
  end

  assign cmd_valid = (fill != '0);
  assign cmd       = queue_mem[rd_ptr];

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'(QDEPTH))
    else $error("command queue overfilled");

endmodule
`default_nettype wire

[hdl/asrs_back.sv]
// Back end: record store, sequence state, acknowledge and peek walk.
`default_nettype none
module asrs_back #(
  parameter int SLOTS_MAX    = asrs_pkg::SLOTS_MAX_DEF,
  parameter int PAYLOAD_BITS = asrs_pkg::PAYLOAD_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_write,
  input  wire logic [asrs_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic                        cmd_valid,
  input  wire asrs_pkg::cmd_t              cmd,
  output logic                             cmd_pop,
  output logic                             resync,
  output logic                             out_strobe,
  output logic [asrs_pkg::SEQ_W-1:0]       out_seq,
  output logic [asrs_pkg::WORD_W-1:0]      out_payload,
  output logic                             last,
  output logic [asrs_pkg::STAT_W-1:0]      status,
  output logic [asrs_pkg::PEND_W-1:0]      pending,
  output logic [asrs_pkg::SEQ_W-1:0]       dropped_total,
  output logic [asrs_pkg::SEQ_W-1:0]       newest_seq
);
  import asrs_pkg::*;

  localparam int CAP_W   = $clog2(SLOTS_MAX + 1);
  localparam int SLOT_W  = $clog2(SLOTS_MAX);
  localparam int ENTRY_W = SEQ_W + PAYLOAD_BITS;

  // Next slot with wrap at the configured capacity.
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] slot,
                                                 input logic [CAP_W-1:0]  cap);
    logic [CAP_W-1:0] s1;
    s1 = CAP_W'(slot) + 1'b1;
    return (s1 == cap) ? '0 : s1[SLOT_W-1:0];
  endfunction

  back_state_t state, state_next;

  logic [CAP_W-1:0]        capacity;
  logic [SEQ_W-1:0]        cap_ext;
  logic [SEQ_W-1:0]        cfg_ext;
  logic [SEQ_W-1:0]        issue_seq;
  logic [SEQ_W-1:0]        acked;
  logic [SEQ_W-1:0]        drop_count;
  logic [SLOT_W-1:0]       next_slot;
  cmd_t                    cur;

  logic [SEQ_W-1:0]        stored_from;
  logic [SEQ_W-1:0]        after_ack;
  logic [SEQ_W-1:0]        first_calc;
  logic [SEQ_W-1:0]        first_q;
  logic [PEND_W-1:0]       pending_q;
  logic [SEQ_W-1:0]        newest_q;

  logic [SEQ_W-1:0]        rep_seq;
  status_t                 rep_status;

  logic [SEQ_W-1:0]        walk_seq;
  logic [SLOT_W-1:0]       walk_slot;
  logic [CNT_W-1:0]        found_cnt;
  logic                    walk_end;
  logic                    held_valid;
  logic [SEQ_W-1:0]        held_seq;
  logic [PAYLOAD_BITS-1:0] held_payload;

  logic [ENTRY_W-1:0]      mem [SLOTS_MAX];
  logic [ENTRY_W-1:0]      rd_data;
  logic [SEQ_W-1:0]        rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_payload;
  logic                    rd_match;
  logic                    mem_we;
  logic                    mem_rd;

  logic                    div_start;
  logic [SEQ_W-1:0]        div_dividend;
  logic                    div_done;
  logic [SLOT_W-1:0]       div_rem;

  logic                    emit;
  logic [SEQ_W-1:0]        e_seq;
  logic [WORD_W-1:0]       e_payload;
  logic                    e_last;
  status_t                 e_status;
  status_t                 out_status;

  assign cap_ext    = SEQ_W'(capacity);
  assign cfg_ext    = SEQ_W'(cfg_data);
  assign rd_seq     = rd_data[ENTRY_W-1 -: SEQ_W];
  assign rd_payload = rd_data[PAYLOAD_BITS-1:0];
  assign rd_match   = (rd_seq == walk_seq);
  assign walk_end   = (walk_seq >= issue_seq) || (found_cnt == cur.count);
  assign status     = out_status;

  // Shared remainder unit for slot pointers.
  asrs_div #(
    .CAP_W  (CAP_W),
    .SLOT_W (SLOT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (capacity),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (resync) begin
          state_next = B_RESYNC;
        end else if (cmd_valid) begin
          state_next = B_EXEC;
        end
      end
      B_RESYNC: begin
        if (div_done) begin
          state_next = B_IDLE;
        end
      end
      B_EXEC:    state_next = (cur.op == OP_PEEK) ? B_DIV : B_FIRST;
      B_FIRST:   state_next = B_PEND;
      B_PEND:    state_next = B_REPORT;
      B_REPORT:  state_next = B_IDLE;
      B_DIV: begin
        if (div_done) begin
          state_next = B_WALK_RD;
        end
      end
      B_WALK_RD: state_next = walk_end ? B_IDLE : B_WALK_CK;
      B_WALK_CK: state_next = B_WALK_RD;
      default:   state_next = B_IDLE;
    endcase
  end

  // Sequencer outputs: queue pop, divider start, memory strobes and result selection.
  always_comb begin
    cmd_pop      = 1'b0;
    div_start    = 1'b0;
    div_dividend = first_q;
    mem_we       = 1'b0;
    mem_rd       = 1'b0;
    emit         = 1'b0;
    e_seq        = '0;
    e_payload    = '0;
    e_last       = 1'b1;
    e_status     = ST_OK;
    unique case (state)
      B_IDLE: begin
        div_dividend = issue_seq;
        div_start    = resync;
        cmd_pop      = !resync && cmd_valid;
      end
      B_EXEC: begin
        div_start = (cur.op == OP_PEEK);
        mem_we    = (cur.op == OP_PUSH);
      end
      B_REPORT: begin
        emit     = 1'b1;
        e_seq    = rep_seq;
        e_status = rep_status;
      end
      B_WALK_RD: begin
        mem_rd = !walk_end;
        if (walk_end) begin
          emit = 1'b1;
          if (held_valid) begin
            e_seq     = held_seq;
            e_payload = WORD_W'(held_payload);
          end else begin
            e_status = ST_NONE_FOUND;
          end
        end
      end
      B_WALK_CK: begin
        // A newly found record releases the one held back, which is then not the final one.
        if (rd_match && held_valid) begin
          emit      = 1'b1;
          e_seq     = held_seq;
          e_payload = WORD_W'(held_payload);
          e_last    = 1'b0;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // State register, capacity and pointer rebuild flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      resync   <= 1'b0;
      capacity <= CAP_W'(SLOTS_MAX);
    end else begin
      state <= state_next;
      if (cfg_write) begin
        resync <= 1'b1;
        if (cfg_ext == '0) begin
          capacity <= CAP_W'(1);
        end else if (cfg_ext > SEQ_W'(SLOTS_MAX)) begin
          capacity <= CAP_W'(SLOTS_MAX);
        end else begin
          capacity <= CAP_W'(cfg_ext);
        end
      end else if (state == B_RESYNC && div_done) begin
        resync <= 1'b0;
      end
    end
  end

  // Sequence, acknowledge and drop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_seq  <= SEQ_W'(1);
      acked      <= '0;
      drop_count <= '0;
      next_slot  <= SLOT_W'(1);
    end else if (state == B_RESYNC && div_done) begin
      next_slot <= div_rem;
    end else if (state == B_EXEC) begin
      case (cur.op)
        OP_PUSH: begin
          if ((issue_seq > cap_ext) && ((issue_seq - cap_ext) > acked)) begin
            drop_count <= drop_count + 1'b1;
          end
          issue_seq <= issue_seq + 1'b1;
          // Sequence zero after the wrap maps to slot zero.
          next_slot <= (issue_seq == '1) ? '0 : slot_inc(next_slot, capacity);
        end
        OP_ACK: begin
          if ((cur.ack_seq > acked) && (cur.ack_seq < issue_seq)) begin
            acked <= cur.ack_seq;
          end
        end
        default: begin
          acked <= acked;
        end
      endcase
    end
  end

  // Oldest unacknowledged sequence, then the pending count from it.
  always_comb begin
    stored_from = (issue_seq > cap_ext) ? (issue_seq - cap_ext) : SEQ_W'(1);
    after_ack   = acked + 1'b1;
    if (issue_seq <= SEQ_W'(1)) begin
      first_calc = SEQ_W'(1);
    end else begin
      first_calc = (stored_from > after_ack) ? stored_from : after_ack;
    end
  end

  always_ff @(posedge clk) begin
    first_q   <= first_calc;
    pending_q <= (issue_seq > first_q) ? PEND_W'(issue_seq - first_q) : '0;
    newest_q  <= (issue_seq == '0) ? '0 : (issue_seq - 1'b1);
  end

  // Command register, single-result reports and the peek walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      found_cnt  <= '0;
    end else begin
      if (cmd_pop) begin
        cur <= cmd;
      end
      if (state == B_EXEC) begin
        walk_seq   <= first_q;
        found_cnt  <= '0;
        held_valid <= 1'b0;
        case (cur.op)
          OP_PUSH: begin
            rep_seq    <= issue_seq;
            rep_status <= ST_OK;
          end
          OP_ACK: begin
            rep_seq    <= '0;
            rep_status <= ((cur.ack_seq > acked) && (cur.ack_seq < issue_seq)) ?
                          ST_OK : ST_ACK_IGNORED;
          end
          OP_BAD_COUNT: begin
            rep_seq    <= '0;
            rep_status <= ST_BAD_COUNT;
          end
          default: begin
            rep_seq    <= '0;
            rep_status <= ST_OK;
          end
        endcase
      end
      if (state == B_DIV && div_done) begin
        walk_slot <= div_rem;
      end
      if (state == B_WALK_CK) begin
        if (rd_match) begin
          found_cnt    <= found_cnt + 1'b1;
          held_valid   <= 1'b1;
          held_seq     <= walk_seq;
          held_payload <= rd_payload;
        end
        walk_seq  <= walk_seq + 1'b1;
        walk_slot <= slot_inc(walk_slot, capacity);
      end
    end
  end

  // Record store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[next_slot] <= {issue_seq, cur.payload[PAYLOAD_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd) begin
      rd_data <= mem[walk_slot];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_strobe <= 1'b0;
    end else begin
      out_strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_seq       <= e_seq;
      out_payload   <= e_payload;
      last          <= e_last;
      out_status    <= e_status;
      pending       <= pending_q;
      dropped_total <= drop_count;
      newest_seq    <= newest_q;
    end
  end

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    !resync |-> (CAP_W'(next_slot) < capacity))
    else $error("write slot beyond capacity");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    (state == B_WALK_RD || state == B_WALK_CK) |-> (found_cnt <= cur.count))
    else $error("peek found more records than allowed");

endmodule
`default_nettype wire

[hdl/acked_sequence_ring_store_core.sv]
// Top level of the acked sequence ring store: front end, back end and their queue.
//
//   Channel   Signals                                          Handshake
//   --------  -----------------------------------------------  -------------------------
//   command   action, record_payload, ack_seq, max_count       start high, busy low
//   config    cfg_data                                         cfg_write high
//   result    out_seq, out_payload, last, status, pending,     out_strobe for one cycle
//             dropped_total, newest_seq
//
// A push, acknowledge or zero-count peek passes the back end states EXEC, FIRST, PEND
// and REPORT from queue pop to the result register, which covers the two-step update of
// the pending count. A peek first takes the slot remainder of the 32-bit start sequence,
// then reads and checks every slot visited on the single memory read port.
// After a capacity write busy stays high while the write slot is rebuilt.
// Reset is synchronous; the record store is not cleared and holds no valid bits.
// The queue holds two items and busy is high when it is full; results are never held off.
`default_nettype none
module acked_sequence_ring_store_core #(
  parameter int SLOTS_MAX    = asrs_pkg::SLOTS_MAX_DEF,
  parameter int PAYLOAD_BITS = asrs_pkg::PAYLOAD_BITS_DEF,
  parameter int PEEK_MAX     = asrs_pkg::PEEK_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [asrs_pkg::ACT_W-1:0]  action,
  input  wire logic [asrs_pkg::WORD_W-1:0] record_payload,
  input  wire logic [asrs_pkg::SEQ_W-1:0]  ack_seq,
  input  wire logic [asrs_pkg::CNT_W-1:0]  max_count,
  input  wire logic                        cfg_write,
  input  wire logic [asrs_pkg::CFG_W-1:0]  cfg_data,
  output logic                             out_strobe,
  output logic [asrs_pkg::SEQ_W-1:0]       out_seq,
  output logic [asrs_pkg::WORD_W-1:0]      out_payload,
  output logic                             last,
  output logic [asrs_pkg::STAT_W-1:0]      status,
  output logic [asrs_pkg::PEND_W-1:0]      pending,
  output logic [asrs_pkg::SEQ_W-1:0]       dropped_total,
  output logic [asrs_pkg::SEQ_W-1:0]       newest_seq
);
  import asrs_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  logic resync;
  cmd_t cmd;

  // Item intake and command queue.
  asrs_front #(
    .PEEK_MAX (PEEK_MAX)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .action         (action),
    .record_payload (record_payload),
    .ack_seq        (ack_seq),
    .max_count      (max_count),
    .resync         (resync),
    .busy           (busy),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  // Command execution and results.
  asrs_back #(
    .SLOTS_MAX    (SLOTS_MAX),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .resync        (resync),
    .out_strobe    (out_strobe),
    .out_seq       (out_seq),
    .out_payload   (out_payload),
    .last          (last),
    .status        (status),
    .pending       (pending),
    .dropped_total (dropped_total),
    .newest_seq    (newest_seq)
  );

endmodule
`default_nettype wire
